[rtl/mrb_pkg.sv]
// shared constants, codes, types and the fill level function for the margin ring buffer
package mrb_pkg;

    localparam int SIZE = 4096;
    localparam int AW   = 12;
    localparam int PW   = AW + 2;

    localparam logic signed [PW-1:0] SIZE_S     = PW'(SIZE);
    localparam logic [AW-1:0]        MARGIN_MAX = AW'(SIZE / 2);
    localparam logic [AW-1:0]        FILL_MAX   = AW'(SIZE - 1);
    localparam logic [6:0]           LEVEL_HIGH = 7'd70;

    localparam logic [2:0] KIND_PUT    = 3'd0;
    localparam logic [2:0] KIND_GET    = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic REG_MARGIN = 1'b0;
    localparam logic REG_STATS  = 1'b1;

    typedef struct packed {
        logic latch;
        logic exec;
        logic copy_rd;
        logic grant;
        logic out_load;
    } mrb_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       need_copy;
        logic       copy_last;
    } mrb_stat_t;

    typedef struct packed {
        logic [11:0] max_fill;
        logic [6:0]  level_percent;
        logic        level_report;
        logic        count_clamped;
        logic [7:0]  read_data;
        logic [11:0] window_count;
        logic [11:0] window_start;
        logic        window_ready;
        logic        accepted;
    } mrb_res_t;

    // fill * 100 / (SIZE - 1) rounded down to tens, done as ten constant compares
    function automatic logic [6:0] level_of(input logic [AW-1:0] fill);
        logic [31:0] f10;
        logic [6:0]  lvl;
        f10 = 32'(fill) * 32'd10;
        lvl = 7'd0;
        for (int k = 1; k <= 10; k++) begin
            if (f10 >= 32'(k * (SIZE - 1))) lvl = 7'(k * 10);
        end
        return lvl;
    endfunction

endpackage

[rtl/mrb_ctrl.sv]
// sequencer for the margin ring buffer: accept, execute, relocation copy, grant, result
module mrb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mrb_pkg::mrb_stat_t stat,
    output mrb_pkg::mrb_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_GRANT  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.latch    = s_tvalid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.kind == mrb_pkg::KIND_GET) begin
                    state_next = stat.need_copy ? ST_COPY : ST_GRANT;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_COPY: begin
                cmd.copy_rd = 1'b1;
                if (stat.copy_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_GRANT;
            end
            ST_GRANT: begin
                cmd.grant  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/mrb_dp.sv]
// datapath: byte store, pointers, window and statistics registers, result word
module mrb_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2:0]         in_kind,
    input  logic [7:0]         in_byte,
    input  logic [11:0]        in_dcount,
    input  logic [11:0]        in_offset,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [11:0]        cfg_wr_data,
    input  mrb_pkg::mrb_cmd_t  cmd,
    output mrb_pkg::mrb_stat_t stat,
    output mrb_pkg::mrb_res_t  res_out,
    output logic [11:0]        margin_out
);

    localparam int AW = mrb_pkg::AW;
    localparam int PW = mrb_pkg::PW;

    logic [7:0]    mem [mrb_pkg::SIZE];
    logic [7:0]    mem_q_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic [2:0]    kind_reg;
    logic [7:0]    byte_reg;
    logic [AW-1:0] dcnt_reg, off_reg;

    logic [AW-1:0] margin_reg, head_reg, tail_reg, granted_reg, peak_reg;
    logic          stats_reg;
    logic [6:0]    last_reg;

    logic [AW-1:0] src_reg, dst_reg, len_reg, cnt_reg, wr_addr_reg;
    logic          wr_pend_reg, rd_ok_reg;

    mrb_pkg::mrb_res_t res_reg, res_next, out_reg, out_next;

    logic signed [PW-1:0] head_s, tail_s, margin_s;
    logic signed [PW-1:0] rest_h, diff_p, room_s, fill_s;
    logic [AW-1:0]        fill_c;
    logic [6:0]           pct;
    logic                 level_new, put_ok;
    logic signed [PW-1:0] rest_t;
    logic [AW-1:0]        dst_c;
    logic [AW-1:0]        dc_eff;
    logic [AW:0]          tdel, raddr13;
    logic [AW-1:0]        tail_del;
    logic                 rd_ok;
    logic signed [PW-1:0] diff_g, c1, c2, c3;
    logic                 grant_ok;
    logic [AW-1:0]        margin_sat;

    assign head_s   = $signed({2'b00, head_reg});
    assign tail_s   = $signed({2'b00, tail_reg});
    assign margin_s = $signed({2'b00, margin_reg});

    // put: free room and fill level
    assign rest_h = mrb_pkg::SIZE_S - head_s;
    assign diff_p = tail_s - head_s;
    always_comb begin
        if (tail_s < margin_s) begin
            room_s = rest_h - PW'(1);
        end else if (diff_p > 0) begin
            room_s = diff_p - PW'(1);
        end else begin
            room_s = mrb_pkg::SIZE_S + diff_p - margin_s - PW'(1);
        end
    end
    assign fill_s = mrb_pkg::SIZE_S - room_s;
    assign fill_c = (fill_s >= mrb_pkg::SIZE_S) ? mrb_pkg::FILL_MAX : fill_s[AW-1:0];
    assign pct    = mrb_pkg::level_of(fill_c);
    assign level_new = (pct != last_reg) &&
                       (((pct >= mrb_pkg::LEVEL_HIGH) && (pct > last_reg)) ||
                        ((pct < mrb_pkg::LEVEL_HIGH) && (last_reg >= mrb_pkg::LEVEL_HIGH)));
    assign put_ok = (room_s > 0);

    // get: wrapped tail shorter than the margin moves below the margin end
    assign rest_t = mrb_pkg::SIZE_S - tail_s;
    assign dst_c  = AW'(margin_s - rest_t);

    // delete
    assign dc_eff   = (dcnt_reg > granted_reg) ? granted_reg : dcnt_reg;
    assign tdel     = {1'b0, tail_reg} + {1'b0, dc_eff};
    assign tail_del = (tdel >= (AW+1)'(mrb_pkg::SIZE)) ? margin_reg : tdel[AW-1:0];

    // read
    assign raddr13 = {1'b0, tail_reg} + {1'b0, off_reg};
    assign rd_ok   = (off_reg < granted_reg) && (raddr13 < (AW+1)'(mrb_pkg::SIZE));

    // grant window
    assign diff_g = head_s - tail_s;
    assign c1 = (diff_g >= 0) ? diff_g : mrb_pkg::SIZE_S + diff_g - margin_s;
    assign c2 = (c1 > rest_t) ? rest_t : c1;
    assign c3 = (c2 < 0) ? '0 : c2;
    assign grant_ok = (c3 >= margin_s) && (c3 != 0);

    assign margin_sat = (cfg_wr_data > mrb_pkg::MARGIN_MAX) ? mrb_pkg::MARGIN_MAX : cfg_wr_data;

    assign stat.kind      = kind_reg;
    assign stat.need_copy = (rest_t < margin_s) && (head_reg < tail_reg);
    assign stat.copy_last = (cnt_reg == len_reg - AW'(1));

    // store ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = head_reg;
        mem_wdata = byte_reg;
        if (wr_pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = mem_q_reg;
        end else if (cmd.exec && (kind_reg == mrb_pkg::KIND_PUT) && put_ok) begin
            mem_we = 1'b1;
        end
        mem_re    = cmd.copy_rd || (cmd.exec && (kind_reg == mrb_pkg::KIND_READ) && rd_ok);
        mem_raddr = cmd.copy_rd ? (src_reg + cnt_reg) : raddr13[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_q_reg <= mem[mem_raddr];
    end

    // result fields built during execute and grant
    always_comb begin
        res_next = res_reg;
        if (cmd.exec) begin
            res_next = '0;
            case (kind_reg)
                mrb_pkg::KIND_PUT: begin
                    if (stats_reg && level_new) begin
                        res_next.level_report  = 1'b1;
                        res_next.level_percent = pct;
                    end
                    if (put_ok) res_next.accepted = 1'b1;
                end
                mrb_pkg::KIND_DELETE: begin
                    res_next.count_clamped = (dcnt_reg > granted_reg);
                    if (dc_eff != '0) res_next.accepted = 1'b1;
                end
                mrb_pkg::KIND_READ: begin
                    res_next.count_clamped = !rd_ok;
                end
                default: ;
            endcase
        end
        if (cmd.grant) begin
            res_next.window_start = tail_reg;
            if (grant_ok) begin
                res_next.window_ready = 1'b1;
                res_next.window_count = c3[AW-1:0];
            end
        end
    end

    always_comb begin
        out_next           = res_reg;
        out_next.read_data = rd_ok_reg ? mem_q_reg : 8'd0;
        out_next.max_fill  = peak_reg;
    end

    // input word and copy bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg <= in_kind;
            byte_reg <= in_byte;
            dcnt_reg <= in_dcount;
            off_reg  <= in_offset;
        end
        if (cmd.exec) begin
            src_reg <= tail_reg;
            dst_reg <= dst_c;
            len_reg <= rest_t[AW-1:0];
            cnt_reg <= '0;
        end else if (cmd.copy_rd) begin
            cnt_reg <= cnt_reg + AW'(1);
        end
        wr_addr_reg <= dst_reg + cnt_reg;
        if (cmd.out_load) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg  <= '0;
            stats_reg   <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            granted_reg <= '0;
            peak_reg    <= '0;
            last_reg    <= '0;
            wr_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            res_reg     <= '0;
        end else begin
            wr_pend_reg <= cmd.copy_rd;
            res_reg     <= res_next;
            if (cfg_wr_en) begin
                if (cfg_addr == mrb_pkg::REG_MARGIN) begin
                    margin_reg  <= margin_sat;
                    head_reg    <= margin_sat;
                    tail_reg    <= margin_sat;
                    granted_reg <= '0;
                    peak_reg    <= '0;
                end else begin
                    stats_reg <= cfg_wr_data[0];
                end
            end
            if (cmd.exec) begin
                rd_ok_reg <= (kind_reg == mrb_pkg::KIND_READ) && rd_ok;
                case (kind_reg)
                    mrb_pkg::KIND_PUT: begin
                        if (stats_reg) begin
                            if (fill_c > peak_reg) peak_reg <= fill_c;
                            if (level_new) last_reg <= pct;
                        end
                        if (put_ok) begin
                            head_reg <= (rest_h <= 1) ? margin_reg : head_reg + AW'(1);
                        end
                    end
                    mrb_pkg::KIND_GET: begin
                        if (stat.need_copy) tail_reg <= dst_c;
                    end
                    mrb_pkg::KIND_DELETE: begin
                        if (dc_eff != '0) begin
                            granted_reg <= granted_reg - dc_eff;
                            tail_reg    <= tail_del;
                        end
                    end
                    mrb_pkg::KIND_CLEAR: begin
                        head_reg    <= margin_reg;
                        tail_reg    <= margin_reg;
                        granted_reg <= '0;
                        peak_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.grant && grant_ok) begin
                granted_reg <= c3[AW-1:0];
            end
        end
    end

    assign res_out    = out_reg;
    assign margin_out = margin_reg;

endmodule

[rtl/margin_ring_buffer.sv]
// top level of the margin ring buffer: byte fifo with a contiguous read window
// One word is handled at a time. A put, delete, read, clear or unknown kind goes through
// execute to the result word after acceptance; a get also passes a grant step, and before it
// a copy and drain step when a wrapped tail of n bytes (n below margin) is moved into the
// relocation area, one byte per cycle through the single read and write port of the
// 4096-byte store. The input is taken again as soon as the result sits in the output
// register, even if that word has not been taken yet. Writing margin (saturated to
// 2048) resets head, tail, grant and peak fill; configure only while idle.
module margin_ring_buffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte_value[7:0], delete_count[19:8], read_offset[31:20]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], window_ready[1], window_start[13:2], window_count[25:14],
    // read_data[33:26], count_clamped[34], level_report[35], level_percent[42:36],
    // max_fill[54:43], zero[55]
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wr_data
);

    mrb_pkg::mrb_cmd_t  cmd;
    mrb_pkg::mrb_stat_t stat;
    mrb_pkg::mrb_res_t  res;
    logic [11:0]        margin;

    mrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrb_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_kind     (s_tuser),
        .in_byte     (s_tdata[7:0]),
        .in_dcount   (s_tdata[19:8]),
        .in_offset   (s_tdata[31:20]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .res_out     (res),
        .margin_out  (margin)
    );

    assign m_tdata = {1'b0, res.max_fill, res.level_percent, res.level_report,
                      res.count_clamped, res.read_data, res.window_count,
                      res.window_start, res.window_ready, res.accepted};

`ifndef SYNTHESIS
    // a granted window is never shorter than the margin
    a_window_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.window_ready) |-> (res.window_count >= margin))
        else $error("window below margin");

    // reported levels are whole tens up to 100
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.level_report) |-> (res.level_percent <= 7'd100))
        else $error("level out of range");

    // no new word is taken while a relocation copy runs
    a_no_accept_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_rd |-> !s_tready)
        else $error("accept during copy");

    // a result word is loaded only when the output register is free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten");
`endif

endmodule

[verif/testbench.sv]
// self-checking testbench for the margin ring buffer: directed rows, then random phases
module testbench;

    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;
    localparam int STALL_LIMIT = 30000;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // byte_value[7:0], delete_count[19:8], read_offset[31:20]
    logic [2:0]  s_tuser = '0;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // accepted[0], window_ready[1], window_start[13:2], window_count[25:14],
    // read_data[33:26], count_clamped[34], level_report[35], level_percent[42:36],
    // max_fill[54:43], zero[55]
    logic [55:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [11:0] cfg_wr_data = '0;

    margin_ring_buffer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // buffer state as predicted
    logic [7:0] fifo_mem [mrb_pkg::SIZE];
    bit         mem_valid [mrb_pkg::SIZE];
    int         head_pos, tail_pos, grant_len, fill_peak, level_last, margin_len;
    bit         stats_on;

    mrb_pkg::mrb_res_t result_q [$];
    int         fail_count = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;

    function automatic void reset_pointers();
        head_pos = margin_len;
        tail_pos = margin_len;
        grant_len = 0;
        fill_peak = 0;
    endfunction

    function automatic mrb_pkg::mrb_res_t buffer_step(logic [2:0] kind, logic [7:0] data,
                                                      int dcount, int offset);
        mrb_pkg::mrb_res_t r;
        int rest, diff, room, fill, pct, dst, cont, t, addr;
        r = '0;
        case (kind)
            mrb_pkg::KIND_PUT: begin
                rest = mrb_pkg::SIZE - head_pos;
                diff = tail_pos - head_pos;
                room = ((tail_pos < margin_len) ? rest :
                        (diff > 0) ? diff : mrb_pkg::SIZE + diff - margin_len) - 1;
                if (stats_on) begin
                    fill = mrb_pkg::SIZE - room;
                    if (fill >= mrb_pkg::SIZE) fill = mrb_pkg::SIZE - 1;
                    if (fill < 0) fill = 0;
                    if (fill > fill_peak) fill_peak = fill;
                    pct = (fill * 100) / (mrb_pkg::SIZE - 1) / 10 * 10;
                    if (pct != level_last && ((pct >= 70 && pct > level_last) ||
                                              (pct < 70 && level_last >= 70))) begin
                        level_last = pct;
                        r.level_report = 1'b1;
                        r.level_percent = 7'(pct);
                    end
                end
                if (room > 0) begin
                    fifo_mem[head_pos] = data;
                    mem_valid[head_pos] = 1'b1;
                    head_pos = (rest <= 1) ? margin_len : head_pos + 1;
                    r.accepted = 1'b1;
                end
            end
            mrb_pkg::KIND_GET: begin
                rest = mrb_pkg::SIZE - tail_pos;
                // short wrapped tail moves down into the relocation area
                if (rest < margin_len && head_pos < tail_pos && rest > 0) begin
                    dst = margin_len - rest;
                    for (int i = 0; i < rest; i++) begin
                        fifo_mem[dst + i] = fifo_mem[tail_pos + i];
                        mem_valid[dst + i] = mem_valid[tail_pos + i];
                    end
                    tail_pos = dst;
                    rest = head_pos - tail_pos;
                end
                diff = head_pos - tail_pos;
                cont = (diff >= 0) ? diff : mrb_pkg::SIZE + diff - margin_len;
                if (cont > rest) cont = rest;
                if (cont < 0) cont = 0;
                if (cont < margin_len) cont = 0;
                r.window_start = 12'(tail_pos);
                if (cont > 0) begin
                    grant_len = cont;
                    r.window_ready = 1'b1;
                    r.window_count = 12'(cont);
                end
            end
            mrb_pkg::KIND_DELETE: begin
                if (dcount > grant_len) begin
                    r.count_clamped = 1'b1;
                    dcount = grant_len;
                end
                if (dcount > 0) begin
                    t = tail_pos + dcount;
                    grant_len -= dcount;
                    if (t >= mrb_pkg::SIZE) t = margin_len;
                    tail_pos = t;
                    r.accepted = 1'b1;
                end
            end
            mrb_pkg::KIND_READ: begin
                addr = tail_pos + offset;
                if (offset < grant_len && addr < mrb_pkg::SIZE) r.read_data = fifo_mem[addr];
                else r.count_clamped = 1'b1;
            end
            mrb_pkg::KIND_CLEAR: reset_pointers();
            default: ;
        endcase
        r.max_fill = 12'(fill_peak);
        return r;
    endfunction

    // present one word, wait for the handshake, then record what must come back
    task automatic send_word(logic [2:0] kind, logic [7:0] data, logic [11:0] dcount,
                             logic [11:0] offset, bit typed, mrb_pkg::mrb_res_t typed_res);
        int gap;
        mrb_pkg::mrb_res_t pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {offset, dcount, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = buffer_step(kind, data, int'(dcount), int'(offset));
        result_q.push_back(typed ? typed_res : pred);
        @(negedge aclk);
    endtask

    task automatic send_random(bit allow_clear);
        logic [2:0] kind;
        logic [11:0] dc, off;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) kind = mrb_pkg::KIND_PUT;
        else if (pick < 57) kind = mrb_pkg::KIND_GET;
        else if (pick < 70) kind = mrb_pkg::KIND_DELETE;
        else if (pick < 92) kind = mrb_pkg::KIND_READ;
        else if (pick < 95 && allow_clear) kind = mrb_pkg::KIND_CLEAR;
        else kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        dc = ($urandom_range(0, 4) == 0) ? 12'($urandom) :
             12'($urandom_range(0, (grant_len < 4000) ? grant_len + 2 : 4095));
        off = ($urandom_range(0, 4) == 0) ? 12'($urandom) :
              12'($urandom_range(0, (grant_len < 4000) ? grant_len + 2 : 4095));
        // never read a location that was not written
        if (kind == mrb_pkg::KIND_READ && int'(off) < grant_len &&
            tail_pos + int'(off) < mrb_pkg::SIZE && !mem_valid[tail_pos + int'(off)])
            off = 12'(grant_len);
        send_word(kind, 8'($urandom), dc, off, 1'b0, '0);
    endtask

    task automatic write_reg(logic addr, logic [11:0] value);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == mrb_pkg::REG_MARGIN) begin
            margin_len = (int'(value) > mrb_pkg::SIZE / 2) ? mrb_pkg::SIZE / 2 : int'(value);
            reset_pointers();
        end else begin
            stats_on = value[0];
        end
    endtask

    task automatic put_word();
        send_word(mrb_pkg::KIND_PUT, 8'($urandom), 12'($urandom), 12'($urandom), 1'b0, '0);
    endtask

    // receiver stall pattern, switching mode now and then
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= (rx_cycle % 4 != 3);
            default: m_tready <= (rx_cycle % 16 < 4);
        endcase
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        mrb_pkg::mrb_res_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("%0t timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = mrb_pkg::mrb_res_t'(m_tdata[54:0]);
                if (result_q.size() == 0) begin
                    $display("%0t unexpected result word %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.accepted !== want.accepted)
                        $display("%0t accepted exp %0d got %0d", $time, want.accepted,
                                 got.accepted);
                    if (got.window_ready !== want.window_ready)
                        $display("%0t window_ready exp %0d got %0d", $time,
                                 want.window_ready, got.window_ready);
                    if (got.window_start !== want.window_start)
                        $display("%0t window_start exp %0d got %0d", $time,
                                 want.window_start, got.window_start);
                    if (got.window_count !== want.window_count)
                        $display("%0t window_count exp %0d got %0d", $time,
                                 want.window_count, got.window_count);
                    if (got.read_data !== want.read_data)
                        $display("%0t read_data exp %h got %h", $time, want.read_data,
                                 got.read_data);
                    if (got.count_clamped !== want.count_clamped)
                        $display("%0t count_clamped exp %0d got %0d", $time,
                                 want.count_clamped, got.count_clamped);
                    if (got.level_report !== want.level_report)
                        $display("%0t level_report exp %0d got %0d", $time,
                                 want.level_report, got.level_report);
                    if (got.level_percent !== want.level_percent)
                        $display("%0t level_percent exp %0d got %0d", $time,
                                 want.level_percent, got.level_percent);
                    if (got.max_fill !== want.max_fill)
                        $display("%0t max_fill exp %0d got %0d", $time, want.max_fill,
                                 got.max_fill);
                    if (m_tdata[55] !== 1'b0)
                        $display("%0t pad bit exp 0 got %b", $time, m_tdata[55]);
                    if (got !== want || m_tdata[55] !== 1'b0) fail_count++;
                end
            end
        end
    end

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [11:0] dcount;
        logic [11:0] offset;
        bit          typed;
        bit          exp_accepted;
        bit          exp_clamped;
    } stim_row_t;

    // margin 0, statistics off, right after reset
    stim_row_t directed_rows [] = '{
        '{mrb_pkg::KIND_READ,   8'h00, 12'd0,    12'd0,    1, 0, 1},
        '{mrb_pkg::KIND_DELETE, 8'h00, 12'd4095, 12'd0,    1, 0, 1},
        '{KIND_SPARE_C,         8'hFF, 12'd4095, 12'd4095, 1, 0, 0},
        '{mrb_pkg::KIND_GET,    8'h00, 12'd0,    12'd0,    1, 0, 0},
        '{mrb_pkg::KIND_PUT,    8'h00, 12'd0,    12'd0,    1, 1, 0},
        '{mrb_pkg::KIND_PUT,    8'hFF, 12'd4095, 12'd4095, 1, 1, 0},
        '{mrb_pkg::KIND_PUT,    8'h5A, 12'd0,    12'd0,    0, 0, 0},
        '{mrb_pkg::KIND_GET,    8'h00, 12'd0,    12'd0,    0, 0, 0},
        '{mrb_pkg::KIND_READ,   8'h00, 12'd0,    12'd0,    0, 0, 0},
        '{mrb_pkg::KIND_READ,   8'h00, 12'd0,    12'd2,    0, 0, 0},
        '{mrb_pkg::KIND_READ,   8'h00, 12'd0,    12'd3,    1, 0, 1},
        '{mrb_pkg::KIND_READ,   8'h00, 12'd0,    12'd4095, 1, 0, 1},
        '{mrb_pkg::KIND_DELETE, 8'h00, 12'd1,    12'd0,    0, 0, 0},
        '{mrb_pkg::KIND_DELETE, 8'h00, 12'd4095, 12'd0,    0, 0, 0},
        '{mrb_pkg::KIND_DELETE, 8'h00, 12'd0,    12'd0,    1, 0, 0},
        '{mrb_pkg::KIND_CLEAR,  8'h00, 12'd0,    12'd0,    1, 0, 0},
        '{mrb_pkg::KIND_PUT,    8'hA5, 12'd0,    12'd0,    0, 0, 0},
        '{KIND_SPARE_A,         8'h00, 12'd0,    12'd0,    1, 0, 0},
        '{KIND_SPARE_B,         8'h00, 12'd0,    12'd0,    1, 0, 0},
        '{mrb_pkg::KIND_GET,    8'h00, 12'd0,    12'd0,    0, 0, 0}
    };

    initial begin
        mrb_pkg::mrb_res_t typed_res;
        int guard;
        margin_len = 0;
        stats_on = 1'b0;
        level_last = 0;
        reset_pointers();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            typed_res = '0;
            typed_res.accepted = directed_rows[i].exp_accepted;
            typed_res.count_clamped = directed_rows[i].exp_clamped;
            send_word(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].dcount,
                      directed_rows[i].offset, directed_rows[i].typed, typed_res);
        end

        // largest margin value saturates
        write_reg(mrb_pkg::REG_MARGIN, 12'hFFF);
        write_reg(mrb_pkg::REG_STATS, 12'd1);
        repeat (15) send_random(1'b1);

        // margin 2040: fill past 70 percent, grant, release, wrap, relocate
        write_reg(mrb_pkg::REG_MARGIN, 12'd2040);
        repeat (2040) put_word();
        send_word(mrb_pkg::KIND_GET, 8'h00, 12'd0, 12'd0, 1'b0, '0);
        if (grant_len > 10)
            send_word(mrb_pkg::KIND_DELETE, 8'h00, 12'(grant_len - 10), 12'd0, 1'b0, '0);
        guard = 0;
        while (!(head_pos < tail_pos && head_pos >= margin_len + 4) && guard < 300) begin
            put_word();
            guard++;
        end
        send_word(mrb_pkg::KIND_GET, 8'h00, 12'd0, 12'd0, 1'b0, '0);
        repeat (20) send_random(1'b0);
        send_word(mrb_pkg::KIND_CLEAR, 8'h00, 12'd0, 12'd0, 1'b0, '0);
        repeat (5) put_word();

        write_reg(mrb_pkg::REG_MARGIN, 12'd0);
        write_reg(mrb_pkg::REG_STATS, 12'd0);
        repeat (30) send_random(1'b1);

        write_reg(mrb_pkg::REG_MARGIN, 12'($urandom_range(1, 16)));
        write_reg(mrb_pkg::REG_STATS, 12'd1);
        repeat (40) send_random(1'b1);

        write_reg(mrb_pkg::REG_MARGIN, 12'd1);
        repeat (30) send_random(1'b1);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_q.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mrb_pkg.sv
rtl/mrb_ctrl.sv
rtl/mrb_dp.sv
rtl/margin_ring_buffer.sv
verif/testbench.sv
